[rtl/lfsc_pkg.sv]
// Shared types, constants and tables for the line-following steering controller.
package lfsc_pkg;

  localparam int WINDOW_DEPTH_DEF = 5;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 31;
  localparam int MUL_W            = 72;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMITED_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARKING_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AXLE_OFFSET  = 3'd4;

  // Gain bands
  localparam logic [2:0] BAND_SLOW = 3'd0;
  localparam logic [2:0] BAND_MID  = 3'd1;
  localparam logic [2:0] BAND_FAST = 3'd2;
  localparam logic [2:0] BAND_TOP  = 3'd3;
  localparam logic [2:0] BAND_PARK = 3'd4;

  // Angle constants, Q3.12; CORDIC gain in Q.30, degrees per radian in Q.16
  localparam logic signed [17:0] PI_Q12      = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12  = 18'sd25736;
  localparam logic signed [17:0] HALF_PI_Q12 = 18'sd6434;
  localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
  localparam logic [31:0]        DEG_PER_RAD = 32'd3754936;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_heading;
    logic        [15:0] speed;
    logic signed [31:0] line_x;
    logic signed [31:0] line_y;
    logic signed [15:0] line_heading;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] steer_angle;
    logic signed [31:0] distance_error;
    logic signed [15:0] heading_error;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_WRAP_P, S_CORD_P, S_MUL_FX, S_MUL_FY, S_WRAP_L, S_CORD_L,
    S_MUL_DX, S_MUL_DY, S_WRAP_E, S_MUL_KD, S_MUL_KA, S_SUM, S_DIV,
    S_LIMIT, S_MUL_DEG, S_DONE
  } state_t;

  // CORDIC arctangent table, Q.16
  function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
    case (i)
      4'd0:    atan_q16 = 20'sd51472;
      4'd1:    atan_q16 = 20'sd30386;
      4'd2:    atan_q16 = 20'sd16055;
      4'd3:    atan_q16 = 20'sd8150;
      4'd4:    atan_q16 = 20'sd4091;
      4'd5:    atan_q16 = 20'sd2047;
      4'd6:    atan_q16 = 20'sd1024;
      4'd7:    atan_q16 = 20'sd512;
      4'd8:    atan_q16 = 20'sd256;
      4'd9:    atan_q16 = 20'sd128;
      4'd10:   atan_q16 = 20'sd64;
      4'd11:   atan_q16 = 20'sd32;
      4'd12:   atan_q16 = 20'sd16;
      4'd13:   atan_q16 = 20'sd8;
      4'd14:   atan_q16 = 20'sd4;
      default: atan_q16 = 20'sd2;
    endcase
  endfunction

  function automatic logic [31:0] kd_gain(input logic [2:0] b);
    case (b)
      BAND_SLOW: kd_gain = 32'd13107;
      BAND_MID:  kd_gain = 32'd1638;
      BAND_FAST: kd_gain = 32'd655;
      BAND_TOP:  kd_gain = 32'd328;
      default:   kd_gain = 32'd19661;
    endcase
  endfunction

  function automatic logic [31:0] ka_gain(input logic [2:0] b);
    case (b)
      BAND_SLOW: ka_gain = 32'd39322;
      BAND_MID:  ka_gain = 32'd32768;
      BAND_FAST: ka_gain = 32'd19661;
      BAND_TOP:  ka_gain = 32'd6554;
      default:   ka_gain = 32'd78643;
    endcase
  endfunction

  function automatic logic signed [MUL_W-1:0] dist_limit(input logic [2:0] b);
    case (b)
      BAND_SLOW: dist_limit = 72'sd308831;
      BAND_MID:  dist_limit = 72'sd2058874;
      BAND_FAST: dist_limit = 72'sd3088311;
      BAND_TOP:  dist_limit = 72'sd2058874;
      default:   dist_limit = 72'sd411775;
    endcase
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [MUL_W-1:0] v);
    if (v > 72'sd32767)       sat16 = 16'sh7FFF;
    else if (v < -72'sd32768) sat16 = 16'sh8000;
    else                      sat16 = v[15:0];
  endfunction

endpackage

[rtl/line_follow_steering_control.sv]
// Top level of the line-following steering controller (sequencer and datapath).
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_item_t
//   out_     output     out_valid/out_stall out_item_t
//   cfg_     input      cfg_we              cfg_index, cfg_data
//
// Most of the work on one item lies in the bit-serial multiplier (one multiplier
// bit per cycle, six products, a seventh for degree output) and the 16-step
// CORDIC, which runs twice; each angle wrap correction adds a step. One item is
// in work at a time.
// Reset is synchronous; there is no clearing pass after it.
// The next item is taken while a finished result waits in the output register.
module line_follow_steering_control #(
  parameter int WINDOW_DEPTH = lfsc_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lfsc_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lfsc_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [lfsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lfsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lfsc_pkg::*;

  localparam int SW = 16 + $clog2(WINDOW_DEPTH);
  localparam int RW = $clog2(WINDOW_DEPTH) + 2;
  localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  state_t state_r, state_nxt;
  in_item_t in_r;

  logic        limited_r, parking_r;
  logic [14:0] steer_limit_r, slew_r;
  logic [30:0] axle_r;

  logic signed [17:0] w_r, w_nxt;
  logic               wrap_done;
  logic signed [33:0] cx_r, cy_r;
  logic signed [19:0] cz_r;
  logic               flip_r;
  logic [3:0]         it_r;

  logic signed [33:0] ps_r, fx_r, fy_r;
  logic signed [17:0] lc_r;
  logic signed [MUL_W-1:0] p_r;
  logic signed [31:0] d_r;
  logic signed [15:0] e_r, u_r, prev_r, cmd_r;

  logic signed [MUL_W-1:0] mul_a_r, mul_acc_r, mul_ld_a, mul_add;
  logic [31:0]        mul_b_r, mul_ld_b;
  logic [5:0]         mul_n_r, mul_ld_n, cnt_r;
  logic               run_r, is_mul, mul_last, sum_last, div_last;

  logic signed [15:0] win_r [WINDOW_DEPTH];
  logic signed [SW-1:0] sum_r;
  logic [SW-1:0]      mag_r;
  logic [RW-1:0]      rem_r, rem_sh;
  logic               neg_r;

  logic               out_valid_r;
  out_item_t          out_r;

  // Derived combinational values
  logic [2:0]         band;
  logic signed [17:0] c_ang;
  logic               c_flip;
  logic signed [33:0] pc_val, psv_val;
  logic signed [17:0] lc_val, ls_val;
  logic signed [MUL_W-1:0] d_raw, d_lim;
  logic signed [15:0] u_val, lim_val;
  logic signed [17:0] lc_cmd, lim_s, st_s;

  // Gain band
  always_comb begin
    if (parking_r)                band = BAND_PARK;
    else if (in_r.speed < 16'd2688) band = BAND_SLOW;
    else if (in_r.speed < 16'd3712) band = BAND_MID;
    else if (in_r.speed < 16'd5248) band = BAND_FAST;
    else                          band = BAND_TOP;
  end

  // Angle wrap, one correction per cycle
  always_comb begin
    wrap_done = (w_r >= -PI_Q12) && (w_r < PI_Q12);
    if (w_r >= PI_Q12)       w_nxt = w_r - TWO_PI_Q12;
    else if (w_r < -PI_Q12)  w_nxt = w_r + TWO_PI_Q12;
    else                     w_nxt = w_r;
  end

  // CORDIC start angle folded into [-pi/2, pi/2]
  always_comb begin
    c_flip = 1'b0;
    c_ang  = w_r;
    if (w_r > HALF_PI_Q12) begin
      c_ang  = w_r - PI_Q12;
      c_flip = 1'b1;
    end else if (w_r < -HALF_PI_Q12) begin
      c_ang  = w_r + PI_Q12;
      c_flip = 1'b1;
    end
  end

  assign pc_val  = flip_r ? -cx_r : cx_r;
  assign psv_val = flip_r ? -cy_r : cy_r;
  assign lc_val  = 18'(pc_val >>> 16);
  assign ls_val  = 18'(psv_val >>> 16);

  // Cross-track distance and its clamp
  always_comb begin
    d_raw = (mul_acc_r - p_r) >>> 14;
    if (d_raw > dist_limit(band))       d_lim = dist_limit(band);
    else if (d_raw < -dist_limit(band)) d_lim = -dist_limit(band);
    else                                d_lim = d_raw;
  end

  // Window mean and limited-mode clamp
  always_comb begin
    u_val  = neg_r ? -16'(mag_r) : 16'(mag_r);
    lim_s  = 18'(steer_limit_r);
    st_s   = 18'(slew_r);
    lc_cmd = 18'(u_val);
    if (lc_cmd > lim_s)             lc_cmd = lim_s;
    if (lc_cmd < -lim_s)            lc_cmd = -lim_s;
    if (lc_cmd > 18'(prev_r) + st_s) lc_cmd = 18'(prev_r) + st_s;
    if (lc_cmd < 18'(prev_r) - st_s) lc_cmd = 18'(prev_r) - st_s;
    lim_val = sat16(MUL_W'(lc_cmd));
  end

  // Multiplier operand select
  always_comb begin
    is_mul   = 1'b1;
    mul_ld_a = '0;
    mul_ld_b = '0;
    mul_ld_n = 6'd32;
    case (state_r)
      S_MUL_FX: begin
        mul_ld_a = MUL_W'(pc_val);
        mul_ld_b = 32'(axle_r);
      end
      S_MUL_FY: begin
        mul_ld_a = MUL_W'(ps_r);
        mul_ld_b = 32'(axle_r);
      end
      S_MUL_DX: begin
        mul_ld_a = MUL_W'(fx_r) - MUL_W'(in_r.line_x);
        mul_ld_b = 32'(ls_val);
        mul_ld_n = 6'd18;
      end
      S_MUL_DY: begin
        mul_ld_a = MUL_W'(fy_r) - MUL_W'(in_r.line_y);
        mul_ld_b = 32'(lc_r);
        mul_ld_n = 6'd18;
      end
      S_MUL_KD: begin
        mul_ld_a = MUL_W'(d_r);
        mul_ld_b = kd_gain(band);
        mul_ld_n = 6'd16;
      end
      S_MUL_KA: begin
        mul_ld_a = MUL_W'(e_r) <<< 4;
        mul_ld_b = ka_gain(band);
        mul_ld_n = 6'd18;
      end
      S_MUL_DEG: begin
        mul_ld_a = MUL_W'(u_r);
        mul_ld_b = DEG_PER_RAD;
        mul_ld_n = 6'd23;
      end
      default: is_mul = 1'b0;
    endcase
  end

  // Multiplier step: top bit of the multiplier carries negative weight
  always_comb begin
    mul_last = run_r && (cnt_r == mul_n_r - 6'd1);
    if (!mul_b_r[0])   mul_add = '0;
    else if (mul_last) mul_add = -mul_a_r;
    else               mul_add = mul_a_r;
  end

  assign sum_last = run_r && (cnt_r == 6'(WINDOW_DEPTH - 1));
  assign div_last = run_r && (cnt_r == 6'(SW - 1));
  assign rem_sh   = {rem_r[RW-2:0], mag_r[SW-1]};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_WRAP_P;
      S_WRAP_P:  if (wrap_done) state_nxt = S_CORD_P;
      S_CORD_P:  if (it_r == 4'd15) state_nxt = S_MUL_FX;
      S_MUL_FX:  if (mul_last) state_nxt = S_MUL_FY;
      S_MUL_FY:  if (mul_last) state_nxt = S_WRAP_L;
      S_WRAP_L:  if (wrap_done) state_nxt = S_CORD_L;
      S_CORD_L:  if (it_r == 4'd15) state_nxt = S_MUL_DX;
      S_MUL_DX:  if (mul_last) state_nxt = S_MUL_DY;
      S_MUL_DY:  if (mul_last) state_nxt = S_WRAP_E;
      S_WRAP_E:  if (wrap_done) state_nxt = S_MUL_KD;
      S_MUL_KD:  if (mul_last) state_nxt = S_MUL_KA;
      S_MUL_KA:  if (mul_last) state_nxt = S_SUM;
      S_SUM:     if (sum_last) state_nxt = S_DIV;
      S_DIV:     if (div_last) state_nxt = S_LIMIT;
      S_LIMIT:   state_nxt = limited_r ? S_DONE : S_MUL_DEG;
      S_MUL_DEG: if (mul_last) state_nxt = S_DONE;
      S_DONE:    if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_stall  = (state_r != S_IDLE);
    out_valid = out_valid_r;
    out_data  = out_r;
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      limited_r     <= 1'b0;
      parking_r     <= 1'b0;
      steer_limit_r <= 15'd1072;
      slew_r        <= 15'd16;
      axle_r        <= 31'd99353;
      prev_r        <= '0;
      run_r         <= 1'b0;
      cnt_r         <= '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) win_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          CFG_LIMITED_MODE: limited_r     <= cfg_data[0];
          CFG_PARKING_MODE: parking_r     <= cfg_data[0];
          CFG_STEER_LIMIT:  steer_limit_r <= cfg_data[14:0];
          CFG_SLEW_STEP:    slew_r        <= cfg_data[14:0];
          CFG_AXLE_OFFSET:  axle_r        <= cfg_data[30:0];
          default: ;
        endcase
      end

      // Step counter shared by multiplier, window sum and divider
      if (is_mul || state_r == S_SUM || state_r == S_DIV) begin
        if (!run_r) begin
          run_r <= 1'b1;
          cnt_r <= '0;
        end else if (mul_last && is_mul || sum_last && state_r == S_SUM
                     || div_last && state_r == S_DIV) begin
          run_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 6'd1;
        end
      end

      // Window push on entry to the sum
      if (state_r == S_SUM && !run_r) begin
        for (int i = WINDOW_DEPTH - 1; i > 0; i--) win_r[i] <= win_r[i-1];
        win_r[0] <= sat16((mul_acc_r - p_r) >>> 20);
      end

      if (state_r == S_LIMIT && limited_r) prev_r <= lim_val;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_r <= in_data;
          w_r  <= 18'(in_data.pose_heading);
        end
      end
      S_WRAP_P, S_WRAP_L: begin
        w_r <= w_nxt;
        if (state_r == S_WRAP_L) fy_r <= 34'(MUL_W'(in_r.pose_y) + (mul_acc_r >>> 30));
        if (wrap_done) begin
          cx_r   <= CORDIC_K;
          cy_r   <= '0;
          cz_r   <= 20'(c_ang) <<< 4;
          flip_r <= c_flip;
          it_r   <= '0;
        end
      end
      S_CORD_P, S_CORD_L: begin
        if (!cz_r[19]) begin
          cx_r <= cx_r - (cy_r >>> it_r);
          cy_r <= cy_r + (cx_r >>> it_r);
          cz_r <= cz_r - atan_q16(it_r);
        end else begin
          cx_r <= cx_r + (cy_r >>> it_r);
          cy_r <= cy_r - (cx_r >>> it_r);
          cz_r <= cz_r + atan_q16(it_r);
        end
        it_r <= it_r + 4'd1;
      end
      S_WRAP_E: begin
        w_r <= w_nxt;
        d_r <= 32'(d_lim);
        if (wrap_done) e_r <= 16'(w_r);
      end
      S_SUM: begin
        if (!run_r) sum_r <= '0;
        else        sum_r <= sum_r + SW'(win_r[cnt_r[IW-1:0]]);
      end
      S_DIV: begin
        if (!run_r) begin
          neg_r <= sum_r[SW-1];
          mag_r <= sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
          rem_r <= '0;
        end else if (rem_sh >= RW'(WINDOW_DEPTH)) begin
          rem_r <= rem_sh - RW'(WINDOW_DEPTH);
          mag_r <= {mag_r[SW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          mag_r <= {mag_r[SW-2:0], 1'b0};
        end
      end
      S_LIMIT: begin
        u_r   <= u_val;
        cmd_r <= lim_val;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_r.steer_angle    <= limited_r ? cmd_r : sat16(mul_acc_r >>> 22);
          out_r.distance_error <= d_r;
          out_r.heading_error  <= e_r;
        end
      end
      default: ;
    endcase

    // Operand captures on the load cycle of each product
    if (is_mul && !run_r) begin
      if (state_r == S_MUL_FX) ps_r <= psv_val;
      if (state_r == S_MUL_FY) fx_r <= 34'(MUL_W'(in_r.pose_x) + (mul_acc_r >>> 30));
      if (state_r == S_MUL_DX) lc_r <= lc_val;
      if (state_r == S_MUL_DY || state_r == S_MUL_KA) p_r <= mul_acc_r;
    end
    if (state_r == S_MUL_FY && mul_last) w_r <= 18'(in_r.line_heading);
    if (state_r == S_MUL_DY && mul_last) w_r <= 18'(in_r.line_heading) - 18'(in_r.pose_heading);

    // Bit-serial multiplier
    if (is_mul) begin
      if (!run_r) begin
        mul_a_r   <= mul_ld_a;
        mul_b_r   <= mul_ld_b;
        mul_n_r   <= mul_ld_n;
        mul_acc_r <= '0;
      end else begin
        mul_acc_r <= mul_acc_r + mul_add;
        mul_a_r   <= mul_a_r <<< 1;
        mul_b_r   <= mul_b_r >> 1;
      end
    end
  end

endmodule

[rtl/lfsc_checker.sv]
// Port-level checker for the steering controller, bound to the top level.
module lfsc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input lfsc_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input lfsc_pkg::out_item_t             out_data,
  input logic                            cfg_we,
  input logic [lfsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [lfsc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lfsc_pkg::*;

  // A result waiting on a stall stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // One item at a time: the input closes after an item is taken
  a_in_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after an item");

  // A result never shows up the cycle after an item is taken
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result too early");

  // Reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind line_follow_steering_control lfsc_checker u_lfsc_checker (.*);
